@@ rtl/pdwm_pkg.sv @@
// Package for the PWM duty window meter.
// Holds the register indexes, data width, reset values, framing bytes, divider constants and output sequencer codes.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package pdwm_pkg;

  // Configuration register indexes.
  localparam logic CFG_WINDOW_SIZE = 1'b0;
  localparam logic CFG_BLINK_TICKS = 1'b1;

  localparam int unsigned CfgDataW = 32;

  // Register reset values.
  localparam logic [15:0] WINDOW_RESET = 16'd60000;
  localparam logic [31:0] BLINK_RESET  = 32'd400000;

  // Framing bytes that follow the scaled count.
  localparam logic [7:0] BYTE_CR = 8'h0D;
  localparam logic [7:0] BYTE_LF = 8'h0A;

  // The scaled count is count / 235.
  // floor(x * 71393 / 2^24) equals floor(x / 235) for every 16-bit x.
  localparam logic [16:0] DIV_RECIP = 17'd71393;
  localparam int unsigned DivShift  = 24;

  // Which byte the output stage loads at its next handoff.
  typedef enum logic [2:0] {
    PH_IDLE = 3'b001,
    PH_CR   = 3'b010,
    PH_LF   = 3'b100
  } phase_t;

endpackage

`default_nettype wire

@@ rtl/pwm_duty_window_meter_top.sv @@
// Top level of the PWM duty window meter: sampling counter, window close logic,
// blink timer and the output stage. Depends on pdwm_pkg.
`timescale 1ns / 1ps
`default_nettype none

// How the block is used
// ---------------------
// Every request on the input channel (in_valid/in_ready, payload pin_level) is one
// sample tick. For window_size ticks the block counts the ticks whose pin_level is
// high. The tick after that takes no sample: it closes the window, compares the
// count with the previous window's count and emits three requests on the output
// channel: the count divided by 235 (saturated at 255), then 0x0D, then 0x0A, with
// last set on 0x0A. A sampling tick emits one request with tx_valid low and last
// high. Every output request also carries the status: differs, fast_blink and the
// count of the last completed window.
// The output request is registered: it appears the cycle after the input is
// taken. A sampling tick is taken every cycle, as long as the receiver keeps up;
// a closing tick holds off the input while the 0x0D and 0x0A go out. The output
// register lets a new tick be taken in the same cycle that the waiting result is
// taken. When the receiver stalls (out_ready low) the result holds and in_ready
// drops until it leaves.
// The configuration port (cfg_we, cfg_index, cfg_data) writes window_size at
// index 0 and blink_ticks at index 1. Synchronous reset (rst) clears the
// counters and flags, empties the output stage and restores the register
// defaults of 60000 and 400000.
module pwm_duty_window_meter_top (
  input  wire logic                          clk,
  input  wire logic                          rst,
  // Input channel.
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic                          pin_level,
  // Output channel.
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic [7:0]                         tx_byte,
  output logic                               tx_valid,
  output logic                               last,
  output logic                               differs,
  output logic                               fast_blink,
  output logic [15:0]                        window_count,
  // Configuration port.
  input  wire logic                          cfg_we,
  input  wire logic                          cfg_index,
  input  wire logic [pdwm_pkg::CfgDataW-1:0] cfg_data
);

  // Configuration registers.
  logic [15:0] window_size;
  logic [31:0] blink_ticks;

  // Measurement state.
  logic [15:0] sample_index;
  logic [15:0] running_count;
  logic [15:0] previous_count;
  logic        differs_flag;
  logic        blink_active;
  logic [31:0] blink_counter;

  logic [15:0] sample_index_next;
  logic [15:0] running_count_next;
  logic [15:0] previous_count_next;
  logic        differs_flag_next;
  logic        blink_active_next;
  logic [31:0] blink_counter_next;

  // Output stage.
  pdwm_pkg::phase_t phase;
  pdwm_pkg::phase_t phase_next;

  logic        in_fire;
  logic        out_fire;
  logic        closing;
  logic        aged_active;
  logic [31:0] aged_counter;
  logic [32:0] recip_product;
  logic [8:0]  quotient;
  logic [7:0]  scaled;

  // A new tick is taken only when no framing byte is still queued and the
  // output register is empty or being emptied this cycle.
  assign in_ready = (phase == pdwm_pkg::PH_IDLE) && (!out_valid || out_ready);
  assign in_fire  = in_valid && in_ready;
  assign out_fire = out_valid && out_ready;

  // The tick closes the window once the sample index reaches the window size.
  assign closing = !(sample_index < window_size);

  // Scale the finished count; the quotient peaks at 278, so it saturates.
  assign recip_product = {17'd0, running_count} * {16'd0, pdwm_pkg::DIV_RECIP};
  assign quotient      = recip_product[pdwm_pkg::DivShift +: 9];
  assign scaled        = quotient[8] ? 8'hFF : quotient[7:0];

  always_comb begin
    // The blink countdown runs at the start of every tick.
    aged_active  = blink_active;
    aged_counter = blink_counter;
    if (blink_active) begin
      if (blink_counter <= 32'd1) begin
        aged_active  = 1'b0;
        aged_counter = 32'd0;
      end else begin
        aged_counter = blink_counter - 32'd1;
      end
    end

    sample_index_next   = sample_index;
    running_count_next  = running_count;
    previous_count_next = previous_count;
    differs_flag_next   = differs_flag;
    blink_active_next   = aged_active;
    blink_counter_next  = aged_counter;

    if (!closing) begin
      sample_index_next = sample_index + 16'd1;
      if (pin_level) begin
        running_count_next = running_count + 16'd1;
      end
    end else begin
      sample_index_next   = 16'd0;
      differs_flag_next   = (running_count != previous_count);
      // A difference while the indication runs leaves its remaining time alone.
      if ((running_count != previous_count) && !aged_active) begin
        blink_active_next  = 1'b1;
        blink_counter_next = blink_ticks;
      end
      previous_count_next = running_count;
      running_count_next  = 16'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      window_size <= pdwm_pkg::WINDOW_RESET;
      blink_ticks <= pdwm_pkg::BLINK_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        pdwm_pkg::CFG_WINDOW_SIZE: window_size <= cfg_data[15:0];
        pdwm_pkg::CFG_BLINK_TICKS: blink_ticks <= cfg_data[31:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sample_index   <= 16'd0;
      running_count  <= 16'd0;
      previous_count <= 16'd0;
      differs_flag   <= 1'b0;
      blink_active   <= 1'b0;
      blink_counter  <= 32'd0;
    end else if (in_fire) begin
      sample_index   <= sample_index_next;
      running_count  <= running_count_next;
      previous_count <= previous_count_next;
      differs_flag   <= differs_flag_next;
      blink_active   <= blink_active_next;
      blink_counter  <= blink_counter_next;
    end
  end

  // Output sequencer: after the scaled byte, the CR and LF go out in turn.
  always_comb begin
    phase_next = phase;
    case (phase)
      pdwm_pkg::PH_IDLE: begin
        if (in_fire && closing) begin
          phase_next = pdwm_pkg::PH_CR;
        end
      end
      pdwm_pkg::PH_CR: begin
        if (out_fire) begin
          phase_next = pdwm_pkg::PH_LF;
        end
      end
      pdwm_pkg::PH_LF: begin
        if (out_fire) begin
          phase_next = pdwm_pkg::PH_IDLE;
        end
      end
      default: phase_next = pdwm_pkg::PH_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase     <= pdwm_pkg::PH_IDLE;
      out_valid <= 1'b0;
    end else begin
      phase <= phase_next;
      if (in_fire) begin
        out_valid <= 1'b1;
      end else if (out_fire && (phase == pdwm_pkg::PH_IDLE)) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Payload of the output register; the status fields hold across the framing bytes.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      tx_byte      <= closing ? scaled : 8'd0;
      tx_valid     <= closing;
      last         <= !closing;
      differs      <= differs_flag_next;
      fast_blink   <= blink_active_next;
      window_count <= previous_count_next;
    end else if (out_fire && (phase == pdwm_pkg::PH_CR)) begin
      tx_byte <= pdwm_pkg::BYTE_CR;
      last    <= 1'b0;
    end else if (out_fire && (phase == pdwm_pkg::PH_LF)) begin
      tx_byte <= pdwm_pkg::BYTE_LF;
      last    <= 1'b1;
    end
  end

endmodule

`default_nettype wire

@@ verif/tb_top.sv @@
// Self-checking testbench for the PWM duty window meter (pwm_duty_window_meter_top).
// A directed table and random short windows are checked against a cycle-free
// predictor. Depends on pdwm_pkg and the RTL top level only.
`timescale 1ns / 1ps

module tb_top;

  // The scaled count byte is the window count divided by this, saturated at 255.
  localparam int NORM_DIV = 235;

  // The directed part is small and the random part stops after about this many ticks.
  localparam int RANDOM_TICKS = 125;

  // Generous bound on the whole run. The slowest legal run, with every long
  // stall landing on every request, stays well below this bound.
  localparam int LIMIT_CYCLES = 2_000_000;

  // One request on the output channel, field by field.
  typedef struct packed {
    logic [7:0]  tx_byte;
    logic        tx_valid;
    logic        last;
    logic        differs;
    logic        fast_blink;
    logic [15:0] window_count;
  } report_t;

  // One row of the directed table. A tick row may carry a typed-in expectation:
  // whether the tick closes a window, the scaled byte, and the status it shows.
  typedef enum logic [1:0] {
    ROW_TICK,
    ROW_WINDOW,
    ROW_BLINK
  } row_kind_t;

  typedef struct packed {
    row_kind_t   kind;
    logic [31:0] value;
    logic        pin;
    logic        typed;
    logic        closes;
    logic [7:0]  scaled;
    logic        differs;
    logic        blink;
    logic [15:0] count;
  } row_t;

  localparam int PLAN_ROWS = 21;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic        pin_level = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [7:0]  tx_byte;
  logic        tx_valid;
  logic        last;
  logic        differs;
  logic        fast_blink;
  logic [15:0] window_count;
  logic        cfg_we = 1'b0;
  logic        cfg_index = 1'b0;
  logic [pdwm_pkg::CfgDataW-1:0] cfg_data = '0;

  pwm_duty_window_meter_top dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .pin_level    (pin_level),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .tx_byte      (tx_byte),
    .tx_valid     (tx_valid),
    .last         (last),
    .differs      (differs),
    .fast_blink   (fast_blink),
    .window_count (window_count),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Reports the meter still owes, oldest first.
  report_t expected_reports[$];

  // The predictor's copy of the registers and of the meter state.
  logic [15:0] win_len;
  logic [31:0] blink_len;
  logic [15:0] tick_pos;
  logic [15:0] high_count;
  logic [15:0] last_count;
  logic        diff_now;
  logic        blink_now;
  logic [31:0] blink_left;

  // When calm is set, neither side idles: this gives stretches at full rate.
  bit      calm = 1'b0;
  // Set while cfg_we is left high so that back-to-back writes need no gap.
  bit      cfg_we_up = 1'b0;
  int      errors = 0;
  int      ticks_sent = 0;
  int      windows_closed = 0;
  int      reports_checked = 0;
  int      cycles = 0;
  int      stall_left = 0;
  int      stall_len;
  report_t want;
  row_t    plan [PLAN_ROWS];

  // Idle lengths: mostly none or short, now and then a long one.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 60) begin
      return 0;
    end
    if (r < 93) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(8, 30);
  endfunction

  function automatic report_t make_report(input logic [7:0] b, input logic txv,
                                          input logic lst, input logic d,
                                          input logic fb, input logic [15:0] c);
    report_t r;
    r.tx_byte      = b;
    r.tx_valid     = txv;
    r.last         = lst;
    r.differs      = d;
    r.fast_blink   = fb;
    r.window_count = c;
    return r;
  endfunction

  // A sampling tick owes one report with no byte; a closing tick owes the scaled
  // count, CR and LF, all three with the same status.
  task automatic queue_reports(input bit closes, input logic [7:0] scaled,
                               input logic d, input logic fb, input logic [15:0] c);
    if (!closes) begin
      expected_reports.push_back(make_report(8'd0, 1'b0, 1'b1, d, fb, c));
    end else begin
      expected_reports.push_back(make_report(scaled, 1'b1, 1'b0, d, fb, c));
      expected_reports.push_back(make_report(pdwm_pkg::BYTE_CR, 1'b1, 1'b0, d, fb, c));
      expected_reports.push_back(make_report(pdwm_pkg::BYTE_LF, 1'b1, 1'b1, d, fb, c));
    end
  endtask

  // Advance the predictor by one accepted tick. The blink countdown runs first,
  // then the tick either samples the pin or closes the window. A window that
  // was shrunk below the current index closes at once.
  task automatic step_meter(input logic pin, input bit publish);
    int   quotient;
    logic [7:0] scaled;
    bit   closes;
    if (blink_now) begin
      if (blink_left <= 32'd1) begin
        blink_now  = 1'b0;
        blink_left = '0;
      end else begin
        blink_left = blink_left - 32'd1;
      end
    end
    closes = (tick_pos >= win_len);
    scaled = 8'd0;
    if (!closes) begin
      tick_pos = tick_pos + 16'd1;
      if (pin) begin
        high_count = high_count + 16'd1;
      end
    end else begin
      tick_pos = '0;
      if (high_count != last_count) begin
        diff_now = 1'b1;
        // A new difference while blinking leaves the running countdown alone.
        if (!blink_now) begin
          blink_now  = 1'b1;
          blink_left = blink_len;
        end
      end else begin
        diff_now = 1'b0;
      end
      last_count = high_count;
      high_count = '0;
      quotient   = int'(last_count) / NORM_DIV;
      scaled     = (quotient > 255) ? 8'hFF : quotient[7:0];
      windows_closed++;
    end
    if (publish) begin
      queue_reports(closes, scaled, diff_now, blink_now, last_count);
    end
  endtask

  // Drop a write enable left high by a previous register write.
  task automatic end_writes();
    if (cfg_we_up) begin
      cfg_we    <= 1'b0;
      cfg_we_up  = 1'b0;
    end
  endtask

  // Offer one tick and wait for the meter to take it. Valid stays high after
  // acceptance so that the next call can follow with no gap; anything that
  // waits in between lowers it first.
  task automatic push_tick(input logic pin, input bit publish);
    int gap;
    end_writes();
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid  <= 1'b1;
    pin_level <= pin;
    do @(posedge clk); while (!in_ready);
    ticks_sent++;
    step_meter(pin, publish);
  endtask

  // Stop offering requests until every owed report has come out. With nothing
  // owed, valid is already low and is left alone.
  task automatic hold_off();
    end_writes();
    if (expected_reports.size() != 0) begin
      in_valid <= 1'b0;
      while (expected_reports.size() != 0) @(posedge clk);
    end
  endtask

  // Write one register once the meter has nothing left to send. The enable is
  // left high so that a second write can follow on the next cycle.
  task automatic write_reg(input logic idx, input logic [31:0] val);
    in_valid <= 1'b0;
    while (expected_reports.size() != 0) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    cfg_we_up  = 1'b1;
    @(posedge clk);
    if (idx == pdwm_pkg::CFG_WINDOW_SIZE) begin
      win_len = val[15:0];
    end else begin
      blink_len = val;
    end
  endtask

  task automatic check_field(input string name, input logic [31:0] exp_v,
                             input logic [31:0] got_v);
    if (got_v !== exp_v) begin
      errors++;
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, exp_v, got_v);
    end
  endtask

  function automatic row_t tick_row(input logic pin);
    row_t r;
    r       = '0;
    r.kind  = ROW_TICK;
    r.pin   = pin;
    return r;
  endfunction

  function automatic row_t seen_row(input logic pin, input logic closes,
                                    input logic [7:0] scaled, input logic d,
                                    input logic fb, input logic [15:0] c);
    row_t r;
    r         = tick_row(pin);
    r.typed   = 1'b1;
    r.closes  = closes;
    r.scaled  = scaled;
    r.differs = d;
    r.blink   = fb;
    r.count   = c;
    return r;
  endfunction

  function automatic row_t reg_row(input row_kind_t kind, input logic [31:0] val);
    row_t r;
    r       = '0;
    r.kind  = kind;
    r.value = val;
    return r;
  endfunction

  // Output side: every accepted request is compared with the oldest owed
  // report. Ready is dropped for random stretches, except in calm phases.
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (expected_reports.size() == 0) begin
        errors++;
        $display("%0t: report with nothing owed, expected none, got byte %0h last %0b",
                 $time, tx_byte, last);
      end else begin
        want = expected_reports.pop_front();
        check_field("tx_byte", 32'(want.tx_byte), 32'(tx_byte));
        check_field("tx_valid", 32'(want.tx_valid), 32'(tx_valid));
        check_field("last", 32'(want.last), 32'(last));
        check_field("differs", 32'(want.differs), 32'(differs));
        check_field("fast_blink", 32'(want.fast_blink), 32'(fast_blink));
        check_field("window_count", 32'(want.window_count), 32'(window_count));
        reports_checked++;
      end
    end
    if (stall_left > 0) begin
      out_ready  <= 1'b0;
      stall_left  = stall_left - 1;
    end else begin
      stall_len = pick_gap();
      if (stall_len > 0) begin
        out_ready  <= 1'b0;
        stall_left  = stall_len - 1;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycles++;
    if (cycles >= LIMIT_CYCLES) begin
      $display("tb_top: errors");
      $finish;
    end
  end

  initial begin
    int   i;
    int   n;
    int   random_ticks;
    logic [15:0] w;
    logic [31:0] b;

    // Predictor starts from the reset state of the meter.
    win_len      = pdwm_pkg::WINDOW_RESET;
    blink_len    = pdwm_pkg::BLINK_RESET;
    tick_pos     = '0;
    high_count   = '0;
    last_count   = '0;
    diff_now     = 1'b0;
    blink_now    = 1'b0;
    blink_left   = '0;
    random_ticks = 0;

    // Directed table. The first ticks run with the reset window of 60000, then
    // the window is shrunk below the current index so that the next tick closes
    // it. A blink length of zero lasts one tick. With a blink length of three,
    // a second difference during the blink must not restart it. A window size
    // of zero closes on every tick with a count of zero.
    plan[0]  = seen_row(1'b1, 1'b0, 8'd0, 1'b0, 1'b0, 16'd0);
    plan[1]  = seen_row(1'b0, 1'b0, 8'd0, 1'b0, 1'b0, 16'd0);
    plan[2]  = seen_row(1'b1, 1'b0, 8'd0, 1'b0, 1'b0, 16'd0);
    plan[3]  = reg_row(ROW_BLINK, 32'd0);
    plan[4]  = reg_row(ROW_WINDOW, 32'd2);
    plan[5]  = seen_row(1'b0, 1'b1, 8'd0, 1'b1, 1'b1, 16'd2);
    plan[6]  = seen_row(1'b1, 1'b0, 8'd0, 1'b1, 1'b0, 16'd2);
    plan[7]  = tick_row(1'b1);
    plan[8]  = seen_row(1'b0, 1'b1, 8'd0, 1'b0, 1'b0, 16'd2);
    plan[9]  = reg_row(ROW_BLINK, 32'd3);
    plan[10] = reg_row(ROW_WINDOW, 32'd1);
    plan[11] = tick_row(1'b1);
    plan[12] = seen_row(1'b0, 1'b1, 8'd0, 1'b1, 1'b1, 16'd1);
    plan[13] = tick_row(1'b0);
    plan[14] = seen_row(1'b1, 1'b1, 8'd0, 1'b1, 1'b1, 16'd0);
    plan[15] = seen_row(1'b1, 1'b0, 8'd0, 1'b1, 1'b0, 16'd0);
    plan[16] = seen_row(1'b0, 1'b1, 8'd0, 1'b1, 1'b1, 16'd1);
    plan[17] = reg_row(ROW_WINDOW, 32'd0);
    plan[18] = seen_row(1'b1, 1'b1, 8'd0, 1'b1, 1'b1, 16'd0);
    plan[19] = seen_row(1'b1, 1'b1, 8'd0, 1'b0, 1'b1, 16'd0);
    plan[20] = seen_row(1'b0, 1'b1, 8'd0, 1'b0, 1'b0, 16'd0);

    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // Rows with a typed-in expectation still run the predictor, so that its
    // state stays in step, but the owed reports come from the table.
    for (i = 0; i < PLAN_ROWS; i++) begin
      case (plan[i].kind)
        ROW_WINDOW: begin
          write_reg(pdwm_pkg::CFG_WINDOW_SIZE, plan[i].value);
        end
        ROW_BLINK: begin
          write_reg(pdwm_pkg::CFG_BLINK_TICKS, plan[i].value);
        end
        default: begin
          push_tick(plan[i].pin, !plan[i].typed);
          if (plan[i].typed) begin
            queue_reports(plan[i].closes, plan[i].scaled, plan[i].differs,
                          plan[i].blink, plan[i].count);
          end
        end
      endcase
    end

    // Let the meter empty out completely before the random part.
    hold_off();

    // Random part: short windows so that closes, differences and blink edges
    // come often, each phase with its own window and blink length. Now and
    // then the sender stops until every owed report is out.
    while (random_ticks < RANDOM_TICKS) begin
      calm = ($urandom_range(0, 3) == 0);
      if ($urandom_range(0, 9) == 0) begin
        w = 16'd0;
      end else begin
        w = 16'($urandom_range(1, 12));
      end
      case ($urandom_range(0, 3))
        0:       b = $urandom_range(0, 2);
        1, 2:    b = $urandom_range(3, 25);
        default: b = $urandom_range(26, 400);
      endcase
      write_reg(pdwm_pkg::CFG_WINDOW_SIZE, {16'd0, w});
      write_reg(pdwm_pkg::CFG_BLINK_TICKS, b);
      n = $urandom_range(8, 30);
      repeat (n) begin
        if ($urandom_range(0, 29) == 0) begin
          hold_off();
        end
        push_tick(1'($urandom_range(0, 1)), 1'b1);
        random_ticks++;
      end
    end
    calm = 1'b0;

    // Drain, then let the clock run on so that any stray request would show.
    hold_off();
    repeat (8) @(posedge clk);

    $display("tb_top: %0d ticks sent, %0d windows closed, %0d reports checked",
             ticks_sent, windows_closed, reports_checked);
    $display("tb_top: windows of 0 to 12 ticks and the reset size, blinks of 0 to 400");
    if (errors == 0) begin
      $display("tb_top: clean");
    end else begin
      $display("tb_top: errors");
    end
    $finish;
  end

endmodule
